// ===== hw/rtl/binary_to_decimal_ascii_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the binary to decimal ASCII converter
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication.
`define B2DA_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define B2DA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/b2da_pkg.sv =====
// ----------------------------------------------------------------------------
// b2da_pkg
// Types, constants and the shift-add-3 step of the decimal converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

  localparam int NUM_WIDTH       = 16;
  localparam int DIGIT_WIDTH     = 4;
  localparam int NUM_DIGITS      = 5;
  localparam int BCD_WIDTH       = NUM_DIGITS * DIGIT_WIDTH;
  localparam int DIGIT_IDX_WIDTH = 3;
  localparam int ASCII_WIDTH     = 6;
  localparam int NUM_STAGES      = 4;
  localparam int STEPS_PER_STAGE = NUM_WIDTH / NUM_STAGES;

  localparam logic [ASCII_WIDTH-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [DIGIT_WIDTH-1:0] ADJUST_MIN  = 4'd5;
  localparam logic [DIGIT_WIDTH-1:0] ADJUST_ADD  = 4'd3;

  typedef struct packed {
    logic [BCD_WIDTH-1:0] bcd;
    logic [NUM_WIDTH-1:0] bin;
  } b2da_work_t;

  // One double-dabble iteration: correct each BCD digit, then shift in one bit.
  function automatic b2da_work_t dabble_step(input b2da_work_t w);
    b2da_work_t           r;
    logic [DIGIT_WIDTH-1:0] d;
    r = w;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      d = r.bcd[i*DIGIT_WIDTH +: DIGIT_WIDTH];
      if (d >= ADJUST_MIN) begin
        r.bcd[i*DIGIT_WIDTH +: DIGIT_WIDTH] = d + ADJUST_ADD;
      end
    end
    r = b2da_work_t'({r.bcd, r.bin} << 1);
    return r;
  endfunction

endpackage

// ===== hw/rtl/binary_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// 16-bit unsigned binary to decimal ASCII characters, leading zeros dropped.
// ----------------------------------------------------------------------------
// A number enters through in_number and leaves as one to five ASCII digits,
// most significant first, with out_last_digit high on the final one; zero
// gives a single '0'. The binary-to-BCD conversion is a four-stage
// double-dabble pipeline that takes a new number every cycle while no full
// stage is held by back-pressure; the digit serializer behind it sends one
// character per cycle while out_ready is high, and takes the next number
// only when idle or as the final digit of the current one transfers, so the
// digit count of each number sets the sustained rate.
module binary_to_decimal_ascii (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [b2da_pkg::NUM_WIDTH-1:0]    in_number,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [b2da_pkg::ASCII_WIDTH-1:0]  out_ascii_digit,
  output logic                              out_last_digit
);
  import b2da_pkg::*;

  logic       stg_valid [NUM_STAGES+1];
  logic       stg_ready [NUM_STAGES+1];
  b2da_work_t stg_work  [NUM_STAGES+1];

  assign stg_valid[0]      = in_valid;
  assign in_ready          = stg_ready[0];
  assign stg_work[0].bcd   = '0;
  assign stg_work[0].bin   = in_number;

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    b2da_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stg_valid[g]),
      .in_ready  (stg_ready[g]),
      .in_work   (stg_work[g]),
      .out_valid (stg_valid[g+1]),
      .out_ready (stg_ready[g+1]),
      .out_work  (stg_work[g+1])
    );
  end

  b2da_serializer u_ser (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (stg_valid[NUM_STAGES]),
    .in_ready        (stg_ready[NUM_STAGES]),
    .in_bcd          (stg_work[NUM_STAGES].bcd),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ascii_digit (out_ascii_digit),
    .out_last_digit  (out_last_digit)
  );

endmodule

// ===== hw/rtl/b2da_stage.sv =====
// ----------------------------------------------------------------------------
// b2da_stage
// One pipeline stage of the converter: STEPS_PER_STAGE shift-add-3 iterations.
// ----------------------------------------------------------------------------
module b2da_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  b2da_pkg::b2da_work_t in_work,
  output logic               out_valid,
  input  logic               out_ready,
  output b2da_pkg::b2da_work_t out_work
);
  import b2da_pkg::*;

  logic       valid_r;
  b2da_work_t work_r;
  b2da_work_t work_nxt;

  // Stage takes a new item when empty or when its item leaves this cycle.
  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_work  = work_r;

  always_comb begin
    work_nxt = in_work;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      work_nxt = dabble_step(work_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      work_r <= work_nxt;
    end
  end

endmodule

// ===== hw/rtl/b2da_serializer.sv =====
// ----------------------------------------------------------------------------
// b2da_serializer
// Holds one converted number and sends its digits out, most significant first.
// ----------------------------------------------------------------------------
module b2da_serializer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [b2da_pkg::BCD_WIDTH-1:0]     in_bcd,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [b2da_pkg::ASCII_WIDTH-1:0]   out_ascii_digit,
  output logic                               out_last_digit
);
  import b2da_pkg::*;

  `include "binary_to_decimal_ascii_assert.svh"

  logic                       busy_r;
  logic [BCD_WIDTH-1:0]       bcd_r;
  logic [DIGIT_IDX_WIDTH-1:0] idx_r;
  logic [DIGIT_IDX_WIDTH-1:0] top_idx;
  logic [DIGIT_WIDTH-1:0]     cur_digit;
  logic                       load;
  logic                       xfer;

  // Highest nonzero digit; zero still prints one digit.
  always_comb begin
    priority if (in_bcd[4*DIGIT_WIDTH +: DIGIT_WIDTH] != '0) top_idx = 3'd4;
    else if (in_bcd[3*DIGIT_WIDTH +: DIGIT_WIDTH] != '0)     top_idx = 3'd3;
    else if (in_bcd[2*DIGIT_WIDTH +: DIGIT_WIDTH] != '0)     top_idx = 3'd2;
    else if (in_bcd[1*DIGIT_WIDTH +: DIGIT_WIDTH] != '0)     top_idx = 3'd1;
    else                                                     top_idx = 3'd0;
  end

  always_comb begin
    unique case (idx_r)
      3'd0:    cur_digit = bcd_r[0*DIGIT_WIDTH +: DIGIT_WIDTH];
      3'd1:    cur_digit = bcd_r[1*DIGIT_WIDTH +: DIGIT_WIDTH];
      3'd2:    cur_digit = bcd_r[2*DIGIT_WIDTH +: DIGIT_WIDTH];
      3'd3:    cur_digit = bcd_r[3*DIGIT_WIDTH +: DIGIT_WIDTH];
      3'd4:    cur_digit = bcd_r[4*DIGIT_WIDTH +: DIGIT_WIDTH];
      default: cur_digit = '0;
    endcase
  end

  assign out_valid       = busy_r;
  assign out_last_digit  = (idx_r == '0);
  assign out_ascii_digit = ASCII_ZERO + {{(ASCII_WIDTH-DIGIT_WIDTH){1'b0}}, cur_digit};
  assign xfer            = out_valid && out_ready;
  // Next number loads as the final digit of the current one transfers.
  assign in_ready        = !busy_r || (xfer && out_last_digit);
  assign load            = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (load) begin
      busy_r <= 1'b1;
    end else if (xfer && out_last_digit) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bcd_r <= in_bcd;
      idx_r <= top_idx;
    end else if (xfer) begin
      idx_r <= idx_r - 3'd1;
    end
  end

  `B2DA_ASSERT_NOW(a_digit_range, out_valid, (out_ascii_digit >= 6'd48) && (out_ascii_digit <= 6'd57), "digit outside 0..9")
  `B2DA_ASSERT_NEXT(a_more_follow, xfer && !out_last_digit, out_valid && (idx_r == $past(idx_r) - 3'd1), "digit sequence broken")
  `B2DA_ASSERT_NOW(a_idx_bound, busy_r, idx_r <= 3'd4, "digit index out of range")

endmodule

// ===== tb/sv/tb_binary_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_to_decimal_ascii
// Self-checking bench for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
// A table of directed numbers (edges of the range, digit-count boundaries,
// alternating bit patterns) runs first, then random numbers under three
// flow-control phases. Every transfer into the block queues the expected
// characters; every character out is compared, field by field, with the
// oldest one waiting.
// ----------------------------------------------------------------------------
module tb_binary_to_decimal_ascii;
  import b2da_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int RESET_CYC   = 12;
  localparam int RAND_ITEMS  = 300;
  localparam int TAIL_CYC    = 20;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DIR_ROWS    = 21;

  typedef struct packed {
    logic [ASCII_WIDTH-1:0] ascii_digit;
    logic                   last_digit;
  } char_t;

  // text_len of zero: expected characters come from the predictor
  typedef struct packed {
    logic [NUM_WIDTH-1:0] number;
    logic [2:0]           text_len;
    logic [39:0]          text;
  } dir_row_t;

  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{16'd0,     3'd1, 40'("0")},
    '{16'd1,     3'd0, 40'd0},
    '{16'd9,     3'd1, 40'("9")},
    '{16'd10,    3'd2, 40'("10")},
    '{16'd99,    3'd0, 40'd0},
    '{16'd100,   3'd0, 40'd0},
    '{16'd999,   3'd0, 40'd0},
    '{16'd1000,  3'd0, 40'd0},
    '{16'd9999,  3'd4, 40'("9999")},
    '{16'd10000, 3'd5, 40'("10000")},
    '{16'd65535, 3'd5, 40'("65535")},
    '{16'd65534, 3'd0, 40'd0},
    '{16'd32768, 3'd0, 40'd0},
    '{16'h5555,  3'd0, 40'd0},
    '{16'hAAAA,  3'd0, 40'd0},
    '{16'd12345, 3'd0, 40'd0},
    '{16'd50000, 3'd0, 40'd0},
    '{16'd255,   3'd0, 40'd0},
    '{16'd256,   3'd0, 40'd0},
    '{16'd1024,  3'd0, 40'd0},
    '{16'd7,     3'd0, 40'd0}
  };

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [NUM_WIDTH-1:0]   in_number;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [ASCII_WIDTH-1:0] out_ascii_digit;
  logic                   out_last_digit;

  char_t       pending_chars[$];
  logic [39:0] row_text      = '0;
  int          row_len       = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          err_count     = 0;
  int          numbers_sent  = 0;
  int          chars_checked = 0;
  int          cycle_count   = 0;

  binary_to_decimal_ascii dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_number       (in_number),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ascii_digit (out_ascii_digit),
    .out_last_digit  (out_last_digit)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  // Decimal digits, most significant first, leading zeros dropped.
  task automatic queue_decimal_chars(input logic [NUM_WIDTH-1:0] n);
    logic [3:0]    digits[NUM_DIGITS];
    int unsigned   rest;
    int            cnt;
    char_t         c;
    rest = n;
    cnt  = 0;
    do begin
      digits[cnt] = 4'(rest % 10);
      rest        = rest / 10;
      cnt++;
    end while (rest != 0 && cnt < NUM_DIGITS);
    for (int k = cnt - 1; k >= 0; k--) begin
      c.ascii_digit = ASCII_ZERO + ASCII_WIDTH'(digits[k]);
      c.last_digit  = (k == 0);
      pending_chars.push_back(c);
    end
  endtask

  task automatic queue_text(input logic [39:0] text, input int len);
    char_t c;
    for (int k = 0; k < len; k++) begin
      c.ascii_digit = text[8*(len-1-k) +: ASCII_WIDTH];
      c.last_digit  = (k == len - 1);
      pending_chars.push_back(c);
    end
  endtask

  function automatic logic [NUM_WIDTH-1:0] pick_number();
    int unsigned roll;
    int unsigned decade;
    roll = $urandom_range(99);
    if (roll < 35) begin
      return NUM_WIDTH'($urandom);
    end else if (roll < 55) begin
      return NUM_WIDTH'($urandom_range(99));
    end else if (roll < 80) begin
      // just around a power of ten, where the digit count changes
      decade = 1;
      repeat ($urandom_range(4)) decade = decade * 10;
      return NUM_WIDTH'(decade - 1 + $urandom_range(2));
    end else begin
      return NUM_WIDTH'($urandom_range(65535, 10000));
    end
  endfunction

  // Handshake sampled mid-cycle: inputs only move at the rising edge, so what
  // is seen here is what the next edge transfers.
  task automatic send_number(input logic [NUM_WIDTH-1:0] n);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_number <= n;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
    numbers_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(negedge clk) begin
    char_t want;
    if (rst_n && in_valid && in_ready) begin
      if (row_len != 0) begin
        queue_text(row_text, row_len);
      end else begin
        queue_decimal_chars(in_number);
      end
    end
    if (rst_n && out_valid && out_ready) begin
      chars_checked++;
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%0h last=%0b",
                                  out_ascii_digit, out_last_digit));
      end else begin
        want = pending_chars.pop_front();
        if (out_ascii_digit !== want.ascii_digit)
          report_mismatch($sformatf("ascii_digit got 0x%0h want 0x%0h",
                                    out_ascii_digit, want.ascii_digit));
        if (out_last_digit !== want.last_digit)
          report_mismatch($sformatf("last_digit got %0b want %0b",
                                    out_last_digit, want.last_digit));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d chars outstanding",
               cycle_count, pending_chars.size());
      $display("tb_binary_to_decimal_ascii: errors");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_number = '0;
    repeat (RESET_CYC) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows; typed-in text replaces the predicted characters
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TABLE[i].text_len != 0) begin
        row_text = DIR_TABLE[i].text;
        row_len  = int'(DIR_TABLE[i].text_len);
        send_number(DIR_TABLE[i].number);
        row_len  = 0;
      end else begin
        send_number(DIR_TABLE[i].number);
      end
    end
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 85 : 0;
      recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 25 : 0;
      for (int i = 0; i < RAND_ITEMS / 3; i++) begin
        send_number(pick_number());
      end
      // hold the input off once until the output side has caught up
      if (phase == 0) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYC) @(posedge clk);
    if (pending_chars.size() != 0)
      report_mismatch($sformatf("%0d chars never arrived", pending_chars.size()));

    $display("sent %0d numbers (range edges, decade boundaries, random) and",
             numbers_sent);
    $display("checked %0d characters under three flow-control phases", chars_checked);
    if (err_count == 0) begin
      $display("tb_binary_to_decimal_ascii: clean");
    end else begin
      $display("tb_binary_to_decimal_ascii: errors");
    end
    $finish;
  end

endmodule
